FILE: design/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Field widths, command codes, register indexes and the divide-by-58 reciprocal.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  localparam int TIMER_W    = 16;
  localparam int DIST_W     = 11;
  localparam int CMD_W      = 2;
  localparam int SENSOR_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_SENSORS_DEF = 3;

  // command codes; the fourth code is a no-op status query
  localparam logic [CMD_W-1:0] CMD_ARM     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'd1;

  localparam logic [TIMER_W-1:0] ECHO_TIMEOUT_RESET = 16'd30000;
  localparam logic [DIST_W-1:0]  MAX_DIST_RESET     = 11'd400;

  // width / 58 as (width * ceil(2^22 / 58)) >> 22, exact for 16-bit widths
  localparam int CM_DIVISOR  = 58;
  localparam int DIV_SHIFT   = 22;
  localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam int DIV_PROD_W  = TIMER_W + 17;

endpackage

`default_nettype wire

FILE: design/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: per-sensor echo state and item pipeline.
// Depends on uer_pkg and uer_range_calc.
//
// Usage:
//   Input channel (in_valid / in_stall): cmd, sensor, capture_value. Arm starts a
//   measurement, the next two captures give rise and fall times, read converts the
//   finished width into a latched distance in cm. Each item yields one result on
//   the output channel (out_valid / out_stall): the addressed sensor's latched
//   distance, ready and measuring flags, all zero for a sensor number out of range.
//   Configuration: cfg_we / cfg_index / cfg_wdata; the user must write only while idle (not enforced).
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while the receiver does not stall; each item reads
//   and updates the state of its sensor between the input and result registers.
// Reset clears all sensor state, sets each latched distance to 400 and restores
//   the timeout (30000 us) and maximum distance (400 cm) registers.
// When the receiver stalls, the result register holds; the input register keeps
//   taking one more item, then in_stall rises until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int NUM_SENSORS = uer_pkg::NUM_SENSORS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [uer_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [uer_pkg::SENSOR_W-1:0]     in_sensor,
  input  wire logic [uer_pkg::TIMER_W-1:0]      in_capture_value,

  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [uer_pkg::DIST_W-1:0]       out_distance_cm,
  output logic                                  out_is_ready,
  output logic                                  out_is_measuring,

  input  wire logic                             cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int SEL_W  = (SIDX_W > uer_pkg::SENSOR_W) ? SIDX_W : uer_pkg::SENSOR_W;

  // configuration registers
  logic [uer_pkg::TIMER_W-1:0] echo_timeout_r;
  logic [uer_pkg::DIST_W-1:0]  max_dist_r;

  // input register
  logic                         in_valid_r;
  logic [uer_pkg::CMD_W-1:0]    in_cmd_r;
  logic [uer_pkg::SENSOR_W-1:0] in_sensor_r;
  logic [uer_pkg::TIMER_W-1:0]  in_cap_r;

  // per-sensor state
  logic [uer_pkg::TIMER_W-1:0] rise_time_r  [NUM_SENSORS];
  logic [uer_pkg::TIMER_W-1:0] pulse_len_r  [NUM_SENSORS];
  logic                        await_fall_r [NUM_SENSORS];
  logic                        busy_r       [NUM_SENSORS];
  logic                        ready_r      [NUM_SENSORS];
  logic [uer_pkg::DIST_W-1:0]  held_dist_r  [NUM_SENSORS];

  // result register
  logic                        out_valid_r;
  logic [uer_pkg::DIST_W-1:0]  out_dist_r;
  logic                        out_ready_r;
  logic                        out_meas_r;

  logic                        adv;
  logic                        in_load;
  logic                        in_range;
  logic                        st_we;
  logic [SEL_W-1:0]            sens_ext;
  logic [SIDX_W-1:0]           sidx;

  logic [uer_pkg::TIMER_W-1:0] cur_rise;
  logic [uer_pkg::TIMER_W-1:0] cur_pulse;
  logic                        cur_await;
  logic                        cur_busy;
  logic                        cur_ready;
  logic [uer_pkg::DIST_W-1:0]  cur_dist;

  logic [uer_pkg::TIMER_W-1:0] rise_nxt;
  logic [uer_pkg::TIMER_W-1:0] pulse_nxt;
  logic                        await_nxt;
  logic                        busy_nxt;
  logic                        ready_nxt;
  logic [uer_pkg::DIST_W-1:0]  dist_nxt;
  logic [uer_pkg::DIST_W-1:0]  calc_dist;

  // handshake
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_load  = !in_valid_r || adv;
  assign in_stall = !in_load;

  assign out_valid        = out_valid_r;
  assign out_distance_cm  = out_dist_r;
  assign out_is_ready     = out_ready_r;
  assign out_is_measuring = out_meas_r;

  // sensor select
  assign sens_ext = SEL_W'(in_sensor_r);
  assign sidx     = SIDX_W'(sens_ext);
  assign in_range = {{(32 - uer_pkg::SENSOR_W){1'b0}}, in_sensor_r} < 32'(NUM_SENSORS);
  assign st_we    = adv && in_range;

  always_comb begin
    cur_rise  = '0;
    cur_pulse = '0;
    cur_await = 1'b0;
    cur_busy  = 1'b0;
    cur_ready = 1'b0;
    cur_dist  = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (sidx == SIDX_W'(i)) begin
        cur_rise  = rise_time_r[i];
        cur_pulse = pulse_len_r[i];
        cur_await = await_fall_r[i];
        cur_busy  = busy_r[i];
        cur_ready = ready_r[i];
        cur_dist  = held_dist_r[i];
      end
    end
  end

  uer_range_calc u_calc (
    .pulse_len    (cur_pulse),
    .echo_timeout (echo_timeout_r),
    .max_dist     (max_dist_r),
    .dist_cm      (calc_dist)
  );

  // command decode for the addressed sensor
  always_comb begin
    rise_nxt  = cur_rise;
    pulse_nxt = cur_pulse;
    await_nxt = cur_await;
    busy_nxt  = cur_busy;
    ready_nxt = cur_ready;
    dist_nxt  = cur_dist;
    case (in_cmd_r)
      uer_pkg::CMD_ARM: begin
        rise_nxt  = '0;
        await_nxt = 1'b0;
        ready_nxt = 1'b0;
        busy_nxt  = 1'b1;
      end
      uer_pkg::CMD_CAPTURE: begin
        if (cur_busy) begin
          if (!cur_await) begin
            rise_nxt  = in_cap_r;
            await_nxt = 1'b1;
          end else begin
            // width wraps modulo the timer range
            pulse_nxt = in_cap_r - cur_rise;
            rise_nxt  = '0;
            await_nxt = 1'b0;
            busy_nxt  = 1'b0;
            ready_nxt = 1'b1;
          end
        end
      end
      uer_pkg::CMD_READ: begin
        if (cur_ready) begin
          ready_nxt = 1'b0;
          dist_nxt  = calc_dist;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_timeout_r <= uer_pkg::ECHO_TIMEOUT_RESET;
      max_dist_r     <= uer_pkg::MAX_DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::CFG_ECHO_TIMEOUT: echo_timeout_r <= cfg_wdata[uer_pkg::TIMER_W-1:0];
        uer_pkg::CFG_MAX_DISTANCE: max_dist_r     <= cfg_wdata[uer_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_cmd_r    <= in_cmd;
      in_sensor_r <= in_sensor;
      in_cap_r    <= in_capture_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        rise_time_r[i]  <= '0;
        pulse_len_r[i]  <= '0;
        await_fall_r[i] <= 1'b0;
        busy_r[i]       <= 1'b0;
        ready_r[i]      <= 1'b0;
        held_dist_r[i]  <= uer_pkg::MAX_DIST_RESET;
      end
    end else begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (st_we && sidx == SIDX_W'(i)) begin
          rise_time_r[i]  <= rise_nxt;
          pulse_len_r[i]  <= pulse_nxt;
          await_fall_r[i] <= await_nxt;
          busy_r[i]       <= busy_nxt;
          ready_r[i]      <= ready_nxt;
          held_dist_r[i]  <= dist_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r  <= in_range ? dist_nxt  : '0;
      out_ready_r <= in_range ? ready_nxt : 1'b0;
      out_meas_r  <= in_range ? busy_nxt  : 1'b0;
    end
  end

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed item produced no result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("pipeline not empty after reset");

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_chk
    a_await_busy: assert property (@(posedge clk) disable iff (!rst_n)
      await_fall_r[g] |-> busy_r[g])
      else $error("awaiting fall edge while not measuring");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
      ready_r[g] |-> !busy_r[g])
      else $error("result ready while still measuring");
  end

endmodule

`default_nettype wire

FILE: design/uer_range_calc.sv
// Pulse width to distance conversion with no-echo substitution.
// Uses uer_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps
`default_nettype none

module uer_range_calc (
  input  wire logic [uer_pkg::TIMER_W-1:0] pulse_len,
  input  wire logic [uer_pkg::TIMER_W-1:0] echo_timeout,
  input  wire logic [uer_pkg::DIST_W-1:0]  max_dist,
  output logic      [uer_pkg::DIST_W-1:0]  dist_cm
);

  logic [uer_pkg::DIV_PROD_W-1:0] prod;
  logic [uer_pkg::DIST_W-1:0]     quot;
  logic                           no_echo;

  assign prod = uer_pkg::DIV_PROD_W'(pulse_len)
              * uer_pkg::DIV_PROD_W'(uer_pkg::DIV_RECIP);
  // quotient tops out at 1129, fits the distance field
  assign quot = prod[uer_pkg::DIV_SHIFT +: uer_pkg::DIST_W];

  assign no_echo = (pulse_len == '0) || (pulse_len > echo_timeout);
  assign dist_cm = no_echo ? max_dist : quot;

endmodule

`default_nettype wire
